FILE: rtl/assert_macros.svh
// Assertion helpers used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ldrs_pkg.sv
package ldrs_pkg;

	// Default sizes
	localparam int DEF_MAX_REQUESTS  = 32;
	localparam int DEF_CYLINDER_BITS = 16;

	// Fixed field widths
	localparam int FIELD_W     = 16;
	localparam int TOTAL_W     = 21;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 56;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_START_HEAD = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DIR  = 8'd1;

	// Control for the shared compare unit
	typedef struct packed {
		logic valid;     // entry data is present this cycle
		logic served;    // entry already served in this batch
		logic phase_up;  // 1: upward sweep, 0: downward sweep
		logic found;     // a candidate is already held
	} cmp_ctrl_t;

endpackage

FILE: rtl/ldrs_ram.sv
module ldrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/ldrs_cmp.sv
module ldrs_cmp
	import ldrs_pkg::*;
#(
	parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
	input  logic [CYLINDER_BITS-1:0] entry,
	input  logic [CYLINDER_BITS-1:0] best,
	input  logic [FIELD_W-1:0]       start_head,
	input  cmp_ctrl_t                ctrl,
	output logic                     take
);

	localparam int DW = (CYLINDER_BITS > FIELD_W) ? CYLINDER_BITS : FIELD_W;

	logic [DW-1:0] entry_ext;
	logic [DW-1:0] head_ext;
	logic          in_group;
	logic          better;

	assign entry_ext = DW'(entry);
	assign head_ext  = DW'(start_head);

	// Upward group sits at or above the start head, downward group below it
	always_comb begin
		if (ctrl.phase_up) begin
			in_group = (entry_ext >= head_ext);
			better   = (entry < best);
		end else begin
			in_group = (entry_ext < head_ext);
			better   = (entry > best);
		end
	end

	// Keep the nearest unserved entry of the current sweep
	assign take = ctrl.valid && !ctrl.served && in_group && (!ctrl.found || better);

endmodule

FILE: rtl/look_disk_request_scheduler.sv
// LOOK disk request scheduler. Cylinder requests stream in one per cycle on
// the s_ side; s_tlast closes the batch and starts scheduling, and s_tready
// stays low until the last result of the batch is in the output register.
// A batch of n requests is served by repeated passes over the request RAM
// through one shared comparator: each pass reads all n entries and picks the
// next request of the current sweep (a pass that finds none reverses the sweep
// once), then the sequencer decides and loads the result into the output
// register. Requests beyond MAX_REQUESTS are dropped. Results leave on the m_
// side with tlast on the last served request; the user must write start_head
// and first_direction on the cfg port between batches, as the block itself
// does not enforce it.
`include "assert_macros.svh"

module look_disk_request_scheduler
	import ldrs_pkg::*;
#(
	parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// requests
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // [15:0] cylinder
	input  logic                   s_tlast,   // batch_end
	// results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // [15:0] served_cylinder,
	                                          // [31:16] seek_distance,
	                                          // [52:32] running_total, [55:53] zero
	output logic                   m_tlast    // order_end
);

	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int DW = (CYLINDER_BITS > FIELD_W) ? CYLINDER_BITS : FIELD_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]               state_q;
	logic [FIELD_W-1:0]       start_head_q;
	logic                     first_dir_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            n_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            served_q;
	logic                     found_q;
	logic                     phase_up_q;
	logic                     second_q;
	logic [MAX_REQUESTS-1:0]  done_q;
	logic [DW-1:0]            head_q;
	logic [TOTAL_W-1:0]       total_q;
	logic                     m_tvalid_q;

	logic                     rd_en_s1;
	logic [AW-1:0]            idx_s1;
	logic                     last_s1;
	logic [CYLINDER_BITS-1:0] best_q;
	logic [AW-1:0]            best_idx_q;
	logic [FIELD_W-1:0]       cyl_out_q;
	logic [FIELD_W-1:0]       dist_out_q;
	logic [TOTAL_W-1:0]       total_out_q;
	logic                     last_out_q;

	logic                     s_fire;
	logic                     full;
	logic                     issue;
	logic                     take;
	logic                     emit_fire;
	logic                     emit_last;
	logic [CYLINDER_BITS-1:0] ram_rdata;
	logic [DW-1:0]            best_ext;
	logic [DW-1:0]            seek_dist;
	logic [TOTAL_W-1:0]       total_nxt;
	logic [CW-1:0]            served_nxt;
	cmp_ctrl_t                cmp_ctrl;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign full      = (count_q == CW'(MAX_REQUESTS));
	assign issue     = (state_q == ST_SCAN) && (idx_q != n_q);
	assign emit_fire = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Seek distance and running total for the picked request
	assign best_ext   = DW'(best_q);
	assign seek_dist  = (head_q >= best_ext) ? (head_q - best_ext) : (best_ext - head_q);
	assign total_nxt  = total_q + TOTAL_W'(seek_dist);
	assign served_nxt = served_q + CW'(1);
	assign emit_last  = (served_nxt == n_q);

	// Request store
	ldrs_ram #(
		.WIDTH (CYLINDER_BITS),
		.DEPTH (MAX_REQUESTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (s_fire && !full),
		.waddr (count_q[AW-1:0]),
		.wdata (CYLINDER_BITS'(s_tdata)),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shared comparator
	assign cmp_ctrl.valid    = rd_en_s1;
	assign cmp_ctrl.served   = done_q[idx_s1];
	assign cmp_ctrl.phase_up = phase_up_q;
	assign cmp_ctrl.found    = found_q;

	ldrs_cmp #(
		.CYLINDER_BITS (CYLINDER_BITS)
	) u_cmp (
		.entry      (ram_rdata),
		.best       (best_q),
		.start_head (start_head_q),
		.ctrl       (cmp_ctrl),
		.take       (take)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= '0;
			first_dir_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_HEAD: start_head_q <= cfg_data;
				REG_FIRST_DIR:  first_dir_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: collect, scan, decide, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			served_q   <= '0;
			found_q    <= 1'b0;
			phase_up_q <= 1'b0;
			second_q   <= 1'b0;
			done_q     <= '0;
			head_q     <= '0;
			total_q    <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
						if (s_tlast) begin
							n_q        <= full ? count_q : (count_q + CW'(1));
							state_q    <= ST_SCAN;
							idx_q      <= '0;
							found_q    <= 1'b0;
							phase_up_q <= first_dir_q;
							second_q   <= 1'b0;
							served_q   <= '0;
							done_q     <= '0;
							head_q     <= DW'(start_head_q);
							total_q    <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (rd_en_s1 && last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (found_q) begin
						state_q <= ST_EMIT;
					end else if (!second_q) begin
						// reverse the sweep
						second_q   <= 1'b1;
						phase_up_q <= !phase_up_q;
						idx_q      <= '0;
						state_q    <= ST_SCAN;
					end else begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						done_q[best_idx_q] <= 1'b1;
						served_q           <= served_nxt;
						head_q             <= best_ext;
						total_q            <= total_nxt;
						if (emit_last) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Read pipeline, candidate and result payload
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q[AW-1:0];
		last_s1 <= (idx_q == (n_q - CW'(1)));
		if (take) begin
			best_q     <= ram_rdata;
			best_idx_q <= idx_s1;
		end
		if (emit_fire) begin
			cyl_out_q   <= FIELD_W'(best_q);
			dist_out_q  <= FIELD_W'(seek_dist);
			total_out_q <= total_nxt;
			last_out_q  <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, total_out_q, dist_out_q, cyl_out_q};
	assign m_tlast  = last_out_q;

	`ASSERT_CLK(a_served_below_n, clk, arst_n, state_q != ST_IDLE |-> served_q < n_q, "served overrun")
	`ASSERT_CLK(a_pick_unserved, clk, arst_n, emit_fire |-> !done_q[best_idx_q], "pick already served")
	`ASSERT_NEXT(a_end_empties, clk, arst_n, emit_fire && emit_last, s_tready && count_q == '0, "not emptied")

endmodule
